// File: src/assert_macros.svh
// Assertion helpers included by positional_array_list_unit.
// Each macro expects a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: src/pal_pkg.sv
package pal_pkg;

    localparam int DEFAULT_CAPACITY = 128;
    localparam int TREE_RADIX       = 8;

    typedef logic signed [31:0] t_word;

    typedef enum logic [2:0] {
        CMD_CLEAR  = 3'd0,
        CMD_APPEND = 3'd1,
        CMD_INSERT = 3'd2,
        CMD_DELETE = 3'd3,
        CMD_READ   = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // What every cell does on an accepted beat.
    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_DEL  = 2'd2
    } t_cell_op;

    typedef struct packed {
        logic     upd;
        t_cell_op op;
        logic     tap_en;
        t_word    value;
    } t_cell_ctl;

    // Number of nodes in level l of the collection tree over n leaves.
    function automatic int pal_level_size(int n, int l);
        int s;
        s = n;
        for (int k = 0; k <= l; k++) begin
            s = (s + TREE_RADIX - 1) / TREE_RADIX;
        end
        return s;
    endfunction

    // Number of register levels needed to reduce n leaves to one node.
    function automatic int pal_tree_levels(int n);
        int s;
        int lv;
        s  = n;
        lv = 0;
        while ((s > 1) || (lv == 0)) begin
            s  = (s + TREE_RADIX - 1) / TREE_RADIX;
            lv = lv + 1;
        end
        return lv;
    endfunction

    // Index of the first node of level l in the flat node array.
    function automatic int pal_level_base(int n, int l);
        int b;
        b = 0;
        for (int k = 0; k < l; k++) begin
            b = b + pal_level_size(n, k);
        end
        return b;
    endfunction

endpackage

// File: src/pal_ifs.sv
interface pal_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         command;
    logic [6:0]         position;
    logic signed [31:0] value;

    modport source (output valid, output command, output position, output value,
                    input ready);
    modport sink (input valid, input command, input position, input value,
                  output ready);
endinterface

interface pal_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic [7:0]         entry_count;
    logic               is_empty_flag;
    logic               is_full_flag;

    modport source (output valid, output read_value, output status, output entry_count,
                    output is_empty_flag, output is_full_flag, input ready);
    modport sink (input valid, input read_value, input status, input entry_count,
                  input is_empty_flag, input is_full_flag, output ready);
endinterface

// File: src/pal_cell.sv
module pal_cell #(
    parameter int IW  = 7,
    parameter int IDX = 0
) (
    input  logic              i_clk,
    input  pal_pkg::t_cell_ctl i_ctl,
    input  logic [IW-1:0]     i_pos,
    input  pal_pkg::t_word    i_left,
    input  pal_pkg::t_word    i_right,
    output pal_pkg::t_word    o_word,
    output pal_pkg::t_word    o_tap
);
    import pal_pkg::*;

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    t_word r_word;
    t_word r_tap;

    // The tap keeps the word as it was before any shift, so a delete returns the old entry.
    always_ff @(posedge i_clk) begin
        if (i_ctl.upd) begin
            r_tap <= (i_ctl.tap_en && (i_pos == MY_IDX)) ? r_word : '0;
            case (i_ctl.op)
                CELL_INS: begin
                    if (MY_IDX > i_pos) begin
                        r_word <= i_left;
                    end else if (MY_IDX == i_pos) begin
                        r_word <= i_ctl.value;
                    end
                end
                CELL_DEL: begin
                    if (MY_IDX >= i_pos) begin
                        r_word <= i_right;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_word = r_word;
    assign o_tap  = r_tap;
endmodule

// File: src/pal_or_tree.sv
module pal_or_tree #(
    parameter int N = 128
) (
    input  logic           i_clk,
    input  pal_pkg::t_word i_taps [N],
    output pal_pkg::t_word o_word
);
    import pal_pkg::*;

    localparam int LEVELS = pal_tree_levels(N);
    localparam int TOTAL  = pal_level_base(N, LEVELS);

    t_word r_node [TOTAL];

    // At most one tap is non-zero, so an OR of the leaves is the selected word.
    for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
        localparam int CUR   = pal_level_size(N, l);
        localparam int BASE  = pal_level_base(N, l);
        localparam int PREV  = (l == 0) ? N : pal_level_size(N, l - 1);
        localparam int PBASE = (l == 0) ? 0 : pal_level_base(N, l - 1);
        for (genvar j = 0; j < CUR; j++) begin : g_node
            t_word w_in [TREE_RADIX];
            t_word n_node;
            for (genvar k = 0; k < TREE_RADIX; k++) begin : g_in
                localparam int SRC = j * TREE_RADIX + k;
                if (SRC >= PREV) begin : g_pad
                    assign w_in[k] = '0;
                end else if (l == 0) begin : g_leaf
                    assign w_in[k] = i_taps[SRC];
                end else begin : g_inner
                    assign w_in[k] = r_node[PBASE + SRC];
                end
            end
            always_comb begin
                n_node = '0;
                for (int k = 0; k < TREE_RADIX; k++) begin
                    n_node = n_node | w_in[k];
                end
            end
            always_ff @(posedge i_clk) begin
                r_node[BASE + j] <= n_node;
            end
        end
    end

    assign o_word = r_node[TOTAL-1];
endmodule

// File: src/positional_array_list_unit.sv
// Positional array list of signed 32-bit words, CAPACITY entries deep.
// Commands arrive as beats on i_cmd (command, position, value); each accepted
// beat produces exactly one result beat on o_res carrying the word read or
// deleted, a status code, the entry count and the empty and full flags.
// The list is a row of cells, one word each. On an accepted beat every cell
// at once holds, loads the new word, takes its lower neighbour's word (insert)
// or its upper neighbour's word (delete), so any insert or delete completes
// at the accepting clock edge. The word read or deleted is collected through
// a registered radix-8 OR tree; the sequencer waits out its levels before
// the result beat is made valid. One command is in flight at a time; the
// next one is accepted in the cycle its predecessor's result is taken.
// If the receiver stalls, the result beat is held unchanged and i_cmd.ready
// stays low. Reset empties the list and drops any result in flight; word
// contents are not cleared, as only entries below the count are ever read.
module positional_array_list_unit #(
    parameter int CAPACITY = pal_pkg::DEFAULT_CAPACITY
) (
    input  logic i_clk,
    input  logic i_rst_n,
    pal_cmd_if.sink   i_cmd,
    pal_res_if.source o_res
);
    import pal_pkg::*;

    localparam int IW     = $clog2(CAPACITY);
    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int CMPW   = (CW > 7) ? CW : 7;
    localparam int LEVELS = pal_tree_levels(CAPACITY);
    localparam int WW     = $clog2(LEVELS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } t_state;

    t_state          r_state;
    logic [WW-1:0]   r_wait;
    logic [CW-1:0]   r_count;
    logic            r_out_valid;
    t_status         r_status;
    logic [7:0]      r_entry_count;
    logic            r_empty;
    logic            r_full;

    logic            w_accept;
    logic            w_list_full;
    logic [CMPW-1:0] w_pos;
    logic [CMPW-1:0] w_cnt;
    t_cmd            w_cmd;
    t_cell_ctl       w_ctl;
    logic [IW-1:0]   w_cell_pos;
    logic [CW-1:0]   n_count;
    t_status         n_status;

    t_word w_word [CAPACITY];
    t_word w_tap  [CAPACITY];
    t_word w_read;

    // Take a new command when idle, or when the pending result leaves this cycle.
    assign i_cmd.ready = (r_state == S_IDLE) || ((r_state == S_DONE) && o_res.ready);
    assign w_accept    = i_cmd.valid && i_cmd.ready;

    assign w_cmd       = t_cmd'(i_cmd.command);
    assign w_pos       = CMPW'(i_cmd.position);
    assign w_cnt       = CMPW'(r_count);
    assign w_list_full = (r_count == CW'(CAPACITY));

    // Command decode. Append is an insert at the current count; a position
    // beyond the capacity is always at or above the count, so it fails the
    // range check before it reaches the cells.
    always_comb begin
        n_count      = r_count;
        n_status     = ST_OK;
        w_cell_pos   = w_pos[IW-1:0];
        w_ctl.upd    = w_accept;
        w_ctl.op     = CELL_HOLD;
        w_ctl.tap_en = 1'b0;
        w_ctl.value  = t_word'(i_cmd.value);
        case (w_cmd)
            CMD_CLEAR: begin
                n_count = '0;
            end
            CMD_APPEND: begin
                if (w_list_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_ctl.op   = CELL_INS;
                    w_cell_pos = r_count[IW-1:0];
                    n_count    = r_count + CW'(1);
                end
            end
            CMD_INSERT: begin
                if (w_list_full) begin
                    n_status = ST_FULL;
                end else if (w_pos > w_cnt) begin
                    n_status = ST_RANGE;
                end else begin
                    w_ctl.op = CELL_INS;
                    n_count  = r_count + CW'(1);
                end
            end
            CMD_DELETE: begin
                if (w_pos >= w_cnt) begin
                    n_status = ST_RANGE;
                end else begin
                    w_ctl.op     = CELL_DEL;
                    w_ctl.tap_en = 1'b1;
                    n_count      = r_count - CW'(1);
                end
            end
            CMD_READ: begin
                if (w_pos >= w_cnt) begin
                    n_status = ST_RANGE;
                end else begin
                    w_ctl.tap_en = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // The row of cells; the end cells see a zero or their own word as the missing neighbour.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        t_word w_left;
        t_word w_right;
        if (i == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_word[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign w_right = w_word[i];
        end else begin : g_mid_r
            assign w_right = w_word[i+1];
        end
        pal_cell #(
            .IW  (IW),
            .IDX (i)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_pos   (w_cell_pos),
            .i_left  (w_left),
            .i_right (w_right),
            .o_word  (w_word[i]),
            .o_tap   (w_tap[i])
        );
    end

    pal_or_tree #(
        .N (CAPACITY)
    ) u_tree (
        .i_clk  (i_clk),
        .i_taps (w_tap),
        .o_word (w_read)
    );

    // Sequencer and result registers. The status fields are captured at
    // acceptance; the read word appears at the tree root once it has settled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wait      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_WALK;
                        r_wait  <= WW'(LEVELS);
                    end
                end
                S_WALK: begin
                    r_wait <= r_wait - WW'(1);
                    if (r_wait == WW'(1)) begin
                        r_state     <= S_DONE;
                        r_out_valid <= 1'b1;
                    end
                end
                S_DONE: begin
                    if (o_res.ready) begin
                        r_out_valid <= 1'b0;
                        if (w_accept) begin
                            r_state <= S_WALK;
                            r_wait  <= WW'(LEVELS);
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (w_accept) begin
                r_count       <= n_count;
                r_status      <= n_status;
                r_entry_count <= 8'(n_count);
                r_empty       <= (n_count == '0);
                r_full        <= (n_count == CW'(CAPACITY));
            end
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.read_value    = w_read;
    assign o_res.status        = r_status;
    assign o_res.entry_count   = r_entry_count;
    assign o_res.is_empty_flag = r_empty;
    assign o_res.is_full_flag  = r_full;

`include "assert_macros.svh"

    `ASSERT_SAME(a_count_bound, 1'b1, r_count <= CW'(CAPACITY))
    `ASSERT_SAME(a_no_overrun, w_accept, !(o_res.valid && !o_res.ready))
    `ASSERT_NEXT(a_walk_after_accept, w_accept, (r_state == S_WALK) && (r_wait == WW'(LEVELS)))
    `ASSERT_SAME(a_valid_after_walk, $rose(o_res.valid), $past(r_wait) == WW'(1))

endmodule

// File: bench/tb_positional_array_list_unit.sv
module tb_positional_array_list_unit;
    import pal_pkg::*;

    // The list is built at its default depth, and the shadow copy below follows it.
    localparam int CAPACITY     = DEFAULT_CAPACITY;
    localparam int RANDOM_ITEMS = 400;
    localparam int MAX_GAP      = 6;       // longest idle a side draws for one beat
    localparam int CALM_SPAN    = 50;      // replies between switches of the taker's mood
    localparam int HOLD_AFTER   = 80;      // commands accepted before the long hold-off
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 12;      // well beyond the tree latency
    localparam int REPORT_LIMIT = 40;
    localparam int RUN_LIMIT    = 2000000;

    // How the random commands lean: towards filling, draining or neither.
    localparam int BIAS_GROW   = 0;
    localparam int BIAS_SHRINK = 1;
    localparam int BIAS_MIX    = 2;

    // Codes above the last real command are accepted and ignored by the block.
    localparam logic [2:0] CMD_SPARE_FIRST = CMD_READ + 3'd1;

    localparam t_word WORD_MAX = 32'sh7fff_ffff;
    localparam t_word WORD_MIN = 32'sh8000_0000;

    typedef struct {
        logic [2:0] op;
        logic [6:0] at;
        t_word      word;
        bit         quiet;   // no idle cycles after this beat
    } t_list_cmd;

    typedef struct {
        t_word      read_value;
        logic [1:0] status;
        logic [7:0] entry_count;
        logic       list_empty;
        logic       is_full;
    } t_reply;

    logic i_clk;
    logic i_rst_n;

    pal_cmd_if cmd_bus ();
    pal_res_if res_bus ();

    positional_array_list_unit #(
        .CAPACITY(CAPACITY)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_bus),
        .o_res  (res_bus)
    );

    // Shadow copy of the list, advanced once for every accepted command beat.
    t_word list_words [CAPACITY];
    int    list_len = 0;

    // Length the list will have once everything queued so far has been applied.
    // The stimulus uses it to aim positions inside or just outside the list.
    int plan_len = 0;

    t_list_cmd queued_commands[$];
    t_reply    awaited_replies[$];

    int items_queued     = 0;
    int commands_offered = 0;
    int commands_taken   = 0;
    int replies_taken    = 0;
    int replies_noted    = 0;
    int mismatch_count   = 0;

    int        send_gap    = 0;
    bit        offer_quiet = 1'b0;
    bit        sender_calm = 1'b0;
    logic      offer_now;
    t_list_cmd next_cmd;

    int   take_stall = 0;
    bit   taker_calm = 1'b0;
    logic take_now;
    logic res_hold;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Reset is released at a falling edge with a nonblocking write, so the
    // drivers sampling it at that same edge still see it asserted.
    initial begin
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Every input of the block has a known value from time zero.
    initial begin
        cmd_bus.valid    = 1'b0;
        cmd_bus.command  = CMD_CLEAR;
        cmd_bus.position = '0;
        cmd_bus.value    = '0;
        res_bus.ready    = 1'b0;
    end

    // Applies one command to the shadow list and returns the reply it should
    // produce. Failed commands leave the list untouched, and a read or delete
    // beyond the end returns zero as its word.
    function automatic t_reply list_apply(logic [2:0] op, logic [6:0] at, t_word word);
        t_reply r;
        int     idx;
        int     i;
        idx           = int'(at);
        r.read_value  = '0;
        r.status      = ST_OK;
        case (op)
            CMD_CLEAR: begin
                list_len = 0;
            end
            CMD_APPEND: begin
                if (list_len >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    list_words[list_len] = word;
                    list_len++;
                end
            end
            CMD_INSERT: begin
                // A full list is reported before a position past the end.
                if (list_len >= CAPACITY) begin
                    r.status = ST_FULL;
                end else if (idx > list_len) begin
                    r.status = ST_RANGE;
                end else begin
                    for (i = list_len; i > idx; i--) begin
                        list_words[i] = list_words[i - 1];
                    end
                    list_words[idx] = word;
                    list_len++;
                end
            end
            CMD_DELETE: begin
                if (idx >= list_len) begin
                    r.status = ST_RANGE;
                end else begin
                    r.read_value = list_words[idx];
                    for (i = idx; i + 1 < list_len; i++) begin
                        list_words[i] = list_words[i + 1];
                    end
                    list_len--;
                end
            end
            CMD_READ: begin
                if (idx >= list_len) begin
                    r.status = ST_RANGE;
                end else begin
                    r.read_value = list_words[idx];
                end
            end
            default: begin
            end
        endcase
        r.entry_count = 8'(list_len);
        r.list_empty  = (list_len == 0);
        r.is_full     = (list_len == CAPACITY);
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("MISMATCH reply %0d %s: got %h, want %h", replies_taken, field, got, want);
        end
    endtask

    task automatic check_reply();
        t_reply want;
        if (awaited_replies.size() == 0) begin
            report_mismatch("beat with no reply awaited", res_bus.read_value, '0);
            return;
        end
        want = awaited_replies.pop_front();
        if (res_bus.read_value !== want.read_value) begin
            report_mismatch("read_value", res_bus.read_value, want.read_value);
        end
        if (res_bus.status !== want.status) begin
            report_mismatch("status", res_bus.status, want.status);
        end
        if (res_bus.entry_count !== want.entry_count) begin
            report_mismatch("entry_count", res_bus.entry_count, want.entry_count);
        end
        if (res_bus.is_empty_flag !== want.list_empty) begin
            report_mismatch("is_empty_flag", res_bus.is_empty_flag, want.list_empty);
        end
        if (res_bus.is_full_flag !== want.is_full) begin
            report_mismatch("is_full_flag", res_bus.is_full_flag, want.is_full);
        end
    endtask

    // Queues one command for the sender and tracks the length the list will
    // reach, so that later positions can be aimed at its current end.
    task automatic queue_command(logic [2:0] op, logic [6:0] at, t_word word);
        t_list_cmd c;
        c.op    = op;
        c.at    = at;
        c.word  = word;
        c.quiet = sender_calm;
        queued_commands.push_back(c);
        items_queued++;
        case (op)
            CMD_CLEAR:  plan_len = 0;
            CMD_APPEND: if (plan_len < CAPACITY) plan_len++;
            CMD_INSERT: if (plan_len < CAPACITY && int'(at) <= plan_len) plan_len++;
            CMD_DELETE: if (int'(at) < plan_len) plan_len--;
            default: begin
            end
        endcase
    endtask

    task automatic queue_random(int bias);
        int         roll;
        int         hi;
        int         w_clear;
        int         w_append;
        int         w_insert;
        int         w_delete;
        int         w_read;
        logic [2:0] op;
        logic [6:0] at;
        t_word      word;
        case (bias)
            BIAS_GROW: begin
                w_clear = 0; w_append = 45; w_insert = 40; w_delete = 5;  w_read = 8;
            end
            BIAS_SHRINK: begin
                w_clear = 1; w_append = 10; w_insert = 10; w_delete = 55; w_read = 21;
            end
            default: begin
                w_clear = 2; w_append = 22; w_insert = 22; w_delete = 25; w_read = 26;
            end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < w_clear) begin
            op = CMD_CLEAR;
        end else if (roll < w_clear + w_append) begin
            op = CMD_APPEND;
        end else if (roll < w_clear + w_append + w_insert) begin
            op = CMD_INSERT;
        end else if (roll < w_clear + w_append + w_insert + w_delete) begin
            op = CMD_DELETE;
        end else if (roll < w_clear + w_append + w_insert + w_delete + w_read) begin
            op = CMD_READ;
        end else begin
            op = CMD_SPARE_FIRST + 3'($urandom_range(0, 2));
        end
        // Most positions land inside the list, some on its last valid slot, and
        // the rest anywhere in the field, which is mostly out of range.
        hi = (op == CMD_INSERT) ? plan_len : plan_len - 1;
        if (hi > CAPACITY - 1) begin
            hi = CAPACITY - 1;
        end
        roll = $urandom_range(0, 99);
        if (hi < 0 || roll < 15) begin
            at = 7'($urandom_range(0, CAPACITY - 1));
        end else if (roll < 25) begin
            at = 7'(hi);
        end else begin
            at = 7'($urandom_range(0, hi));
        end
        case ($urandom_range(0, 11))
            0:       word = WORD_MAX;
            1:       word = WORD_MIN;
            2:       word = '0;
            3:       word = '1;
            default: word = $urandom;
        endcase
        queue_command(op, at, word);
    endtask

    // Sender: drives a command beat at the falling edge and holds it until the
    // block takes it. After each beat it idles for a drawn number of cycles,
    // unless the beat was queued during a quiet stretch.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            cmd_bus.valid <= 1'b0;
        end else begin
            offer_now = cmd_bus.valid;
            if (cmd_bus.valid && commands_taken == commands_offered) begin
                offer_now = 1'b0;
                send_gap  = offer_quiet ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (!offer_now) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (queued_commands.size() != 0) begin
                    next_cmd = queued_commands.pop_front();
                    cmd_bus.command  <= next_cmd.op;
                    cmd_bus.position <= next_cmd.at;
                    cmd_bus.value    <= next_cmd.word;
                    offer_quiet      = next_cmd.quiet;
                    commands_offered++;
                    offer_now        = 1'b1;
                end
            end
            // A single write per edge, so a beat that follows straight on keeps
            // valid high without a glitch.
            cmd_bus.valid <= offer_now;
        end
    end

    // Taker: after each reply beat it draws a stall, switching every so often
    // between a stalling mood and a calm one. The long hold-off overrides both.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
        end else begin
            if (replies_taken != replies_noted) begin
                replies_noted = replies_taken;
                if (replies_taken % CALM_SPAN == 0) begin
                    taker_calm = !taker_calm;
                end
                take_stall = taker_calm ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (take_stall > 0) begin
                take_stall--;
                take_now = 1'b0;
            end else begin
                take_now = 1'b1;
            end
            res_bus.ready <= take_now && !res_hold;
        end
    end

    // Long hold-off: the taker refuses replies for a stretch while the sender
    // keeps offering, so the block holds its reply and stops taking commands.
    // The flag changes at the rising edge and is read at the falling one.
    initial begin
        res_hold = 1'b0;
        while (commands_taken < HOLD_AFTER) @(posedge i_clk);
        res_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        res_hold = 1'b0;
    end

    // Monitor: both handshakes are sampled at the rising edge. The reply is
    // checked before a command taken at the same edge is predicted, as that
    // reply always belongs to an earlier command.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_bus.valid && res_bus.ready) begin
                check_reply();
                replies_taken <= replies_taken + 1;
            end
            if (cmd_bus.valid && cmd_bus.ready) begin
                awaited_replies.push_back(list_apply(cmd_bus.command, cmd_bus.position,
                                                     cmd_bus.value));
                commands_taken <= commands_taken + 1;
            end
        end
    end

    initial begin : stimulus
        int episode;

        // Directed part: empty-list errors, the word extremes, insert at the
        // front, at the end and past the end, reads at both ends and out of range,
        // deletes in the middle, at the end and out of range, the ignored codes with
        // every position bit set, and clears.
        queue_command(CMD_READ,   7'd0,   32'sd0);
        queue_command(CMD_DELETE, 7'd0,   32'sd0);
        queue_command(CMD_INSERT, 7'd1,   WORD_MAX);
        queue_command(CMD_APPEND, 7'd127, WORD_MAX);
        queue_command(CMD_APPEND, 7'd0,   WORD_MIN);
        queue_command(CMD_INSERT, 7'd0,   '1);
        queue_command(CMD_INSERT, 7'd3,   32'sd0);
        queue_command(CMD_INSERT, 7'd5,   32'sh1234_5678);
        queue_command(CMD_READ,   7'd0,   32'sd0);
        queue_command(CMD_READ,   7'd3,   32'sd0);
        queue_command(CMD_READ,   7'd4,   32'sd0);
        queue_command(CMD_READ,   7'd127, 32'sd0);
        queue_command(CMD_DELETE, 7'd1,   32'sd0);
        queue_command(CMD_DELETE, 7'd2,   32'sd0);
        queue_command(CMD_DELETE, 7'd127, 32'sd0);
        for (int k = 0; k < 3; k++) begin
            queue_command(CMD_SPARE_FIRST + 3'(k), 7'd127, WORD_MIN);
        end
        queue_command(CMD_CLEAR,  7'd127, WORD_MAX);
        queue_command(CMD_READ,   7'd0,   32'sd0);
        queue_command(CMD_APPEND, 7'd0,   32'sh5555_5555);
        queue_command(CMD_INSERT, 7'd0,   32'shaaaa_aaaa);
        queue_command(CMD_CLEAR,  7'd0,   32'sd0);

        // The stimulus waits here until every reply of the directed part is in.
        while (replies_taken < items_queued) @(posedge i_clk);

        // Random part in episodes: fill the list to capacity and poke at it
        // while full, wander about, drain it to empty and poke at that, and
        // so on. Some episodes run the sender without idle cycles.
        episode = 0;
        while (items_queued < RANDOM_ITEMS) begin
            sender_calm = ($urandom_range(0, 2) == 0);
            case (episode % 4)
                0: begin
                    while (plan_len < CAPACITY) queue_random(BIAS_GROW);
                    repeat (12) queue_random(BIAS_MIX);
                end
                2: begin
                    while (plan_len > 0) queue_random(BIAS_SHRINK);
                    repeat (6) queue_random(BIAS_SHRINK);
                end
                default: begin
                    repeat (40) queue_random(BIAS_MIX);
                end
            endcase
            episode++;
        end

        while (replies_taken < items_queued) @(posedge i_clk);
        // A few more cycles, ending on a falling edge, catch any stray reply.
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
